@@ rtl/core/range_gap_allocator_macros.svh @@
// assertion macros for the range gap allocator checker
`ifndef RANGE_GAP_ALLOCATOR_MACROS_SVH
`define RANGE_GAP_ALLOCATOR_MACROS_SVH

// clocked check, quiet while reset is asserted
`define RGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication from one condition to the next cycle
`define RGA_ASSERT_NEXT(lbl, cond, conseq, msg) \
  `RGA_ASSERT(lbl, (cond) |=> (conseq), msg)

`endif

@@ rtl/core/rga_pkg.sv @@
// shared types and constants of the range gap allocator
`default_nettype none
package rga_pkg;
  localparam int MAX_NODES = 32;
  localparam int ADDR_BITS = 32;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int WW        = ADDR_BITS + 4;
  localparam int SIZE_W    = ADDR_BITS + 1;

  typedef logic [WW-1:0] wide_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_HIGH  = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic CFG_SPAN_START = 1'b0;
  localparam logic CFG_SPAN_SIZE  = 1'b1;

  typedef struct packed {
    logic    load_req;
    logic    clr_idx;
    logic    inc_idx;
    logic    gap_a;
    logic    gap_b;
    logic    ins_shift;
    logic    rem_shift;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic invalid;
    logic full;
    logic idx_end;
    logic fit;
    logic stop;
    logic found;
    logic pos_hit;
    logic key_hit;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

@@ rtl/core/rga_ctrl.sv @@
// sequencer for insert walk, position search and remove
`default_nettype none
module rga_ctrl import rga_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  wire   out_ready,
  input  stat_t st,
  output cmd_t  cmd
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_GAPA  = 9'b000000100,
    S_GAPB  = 9'b000001000,
    S_POS   = 9'b000010000,
    S_PLACE = 9'b000100000,
    S_RSCAN = 9'b001000000,
    S_RDEL  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    cmd            = '0;
    cmd.out_status = res_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cmd.clr_idx  = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.mode == MODE_REMOVE) begin
          state_nxt = S_RSCAN;
        end else if (st.invalid) begin
          res_nxt   = ST_INVALID;
          state_nxt = S_DONE;
        end else if (st.full) begin
          res_nxt   = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_GAPA;
        end
      end
      S_GAPA: begin
        cmd.gap_a = 1'b1;
        state_nxt = S_GAPB;
      end
      S_GAPB: begin
        cmd.gap_b = 1'b1;
        if (st.stop || st.idx_end) begin
          if (st.found || st.fit) begin
            cmd.clr_idx = 1'b1;
            state_nxt   = S_POS;
          end else begin
            res_nxt   = ST_NOSPACE;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_GAPA;
        end
      end
      S_POS: begin
        if (st.pos_hit) state_nxt = S_PLACE;
        else cmd.inc_idx = 1'b1;
      end
      S_PLACE: begin
        cmd.ins_shift = 1'b1;
        res_nxt       = ST_OK;
        state_nxt     = S_DONE;
      end
      S_RSCAN: begin
        if (st.idx_end) begin
          res_nxt   = ST_NOTFOUND;
          state_nxt = S_DONE;
        end else if (st.key_hit) begin
          state_nxt = S_RDEL;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_RDEL: begin
        cmd.rem_shift = 1'b1;
        res_nxt       = ST_OK;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to drain
        if (!st.out_busy || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/rga_datapath.sv @@
// range table, span registers, gap evaluation and result register
`default_nettype none
module rga_datapath import rga_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire                  cfg_index,
  input  wire [SIZE_W-1:0]     cfg_wdata,
  input  wire                  in_mode,
  input  wire [SIZE_W-1:0]     in_alloc_size,
  input  wire [ADDR_BITS-1:0]  in_alignment,
  input  wire [ADDR_BITS-1:0]  in_range_start,
  input  wire [SIZE_W-1:0]     in_range_end,
  input  wire [1:0]            in_fit_policy,
  input  wire                  in_once_flag,
  input  wire [ADDR_BITS-1:0]  in_node_start,
  input  wire                  out_valid,
  output logic [2:0]           out_status,
  output logic [ADDR_BITS-1:0] out_placed_start,
  input  cmd_t                 cmd,
  output stat_t                st
);
  logic [ADDR_BITS-1:0] starts_r [MAX_NODES];
  logic [SIZE_W-1:0]    lens_r   [MAX_NODES];
  logic [CNT_W-1:0]     count_r;
  logic [ADDR_BITS-1:0] span_start_r;
  logic [SIZE_W-1:0]    span_size_r;

  logic                 mode_r, once_r;
  logic [SIZE_W-1:0]    size_r, win_hi_r;
  logic [ADDR_BITS-1:0] align_r, win_lo_r, key_r;
  logic [1:0]           policy_r;
  wide_t                span_end_r, prev_end_r, lo_r, hi_r, best_r, chosen_r;
  logic                 found_r;
  logic [CNT_W-1:0]     idx_r;
  logic [2:0]           out_status_r;
  logic [ADDR_BITS-1:0] out_placed_r;

  logic [IDX_W-1:0]     rd_idx;
  logic                 idx_in;
  logic [ADDR_BITS-1:0] rd_start;
  logic [SIZE_W-1:0]    rd_len;
  wide_t                span_sum, top, lo_raw, hi_raw, lo_c, hi_c, amask, s, gap;
  logic                 fit, stop;

  assign rd_idx   = idx_r[IDX_W-1:0];
  assign idx_in   = idx_r < count_r;
  assign rd_start = starts_r[rd_idx];
  assign rd_len   = lens_r[rd_idx];

  assign span_sum = wide_t'(span_start_r) + wide_t'(span_size_r);
  assign top      = wide_t'(1) << ADDR_BITS;

  // clip the current gap to the request window
  assign lo_raw = (idx_r == '0) ? wide_t'(span_start_r) : prev_end_r;
  assign hi_raw = idx_in ? wide_t'(rd_start) : span_end_r;
  assign lo_c   = (lo_raw < wide_t'(win_lo_r)) ? wide_t'(win_lo_r) : lo_raw;
  assign hi_c   = (hi_raw > wide_t'(win_hi_r)) ? wide_t'(win_hi_r) : hi_raw;

  assign amask = wide_t'(align_r) - wide_t'(1);
  assign s     = (align_r == '0) ? lo_r : ((lo_r + amask) & ~amask);
  assign fit   = (lo_r < hi_r) && ((s + wide_t'(size_r)) <= hi_r);
  assign gap   = hi_r - lo_r;
  assign stop  = fit && ((policy_r == POL_BEST || policy_r == POL_HIGH) ? once_r : 1'b1);

  always_comb begin
    st          = '0;
    st.mode     = mode_r;
    st.invalid  = (size_r == '0) || ({1'b0, win_lo_r} >= win_hi_r) ||
                  ((align_r != '0) && ((align_r & (align_r - 1'b1)) != '0));
    st.full     = (count_r == CNT_W'(MAX_NODES));
    st.idx_end  = !idx_in;
    st.fit      = fit;
    st.stop     = stop;
    st.found    = found_r;
    st.pos_hit  = !idx_in || (wide_t'(rd_start) >= chosen_r);
    st.key_hit  = (rd_start == key_r);
    st.out_busy = out_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      span_start_r <= '0;
      span_size_r  <= '0;
    end else begin
      if (cfg_wr_en && cfg_index == CFG_SPAN_START) span_start_r <= cfg_wdata[ADDR_BITS-1:0];
      if (cfg_wr_en && cfg_index == CFG_SPAN_SIZE)  span_size_r  <= cfg_wdata;
      if (cmd.ins_shift) count_r <= count_r + 1'b1;
      else if (cmd.rem_shift) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode_r     <= in_mode;
      size_r     <= in_alloc_size;
      align_r    <= in_alignment;
      win_lo_r   <= in_range_start;
      win_hi_r   <= in_range_end;
      policy_r   <= in_fit_policy;
      once_r     <= in_once_flag;
      key_r      <= in_node_start;
      span_end_r <= (span_sum > top) ? top : span_sum;
      found_r    <= 1'b0;
      best_r     <= '1;
      chosen_r   <= '0;
    end
    if (cmd.clr_idx) idx_r <= '0;
    else if (cmd.inc_idx) idx_r <= idx_r + 1'b1;
    if (cmd.gap_a) begin
      lo_r <= lo_c;
      hi_r <= hi_c;
      if (idx_in) prev_end_r <= wide_t'(rd_start) + wide_t'(rd_len);
    end
    if (cmd.gap_b && fit) begin
      found_r <= 1'b1;
      if (policy_r == POL_BEST) begin
        if (gap < best_r) begin
          best_r   <= gap;
          chosen_r <= s;
        end
      end else begin
        chosen_r <= s;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_placed_r <= (cmd.out_status == ST_OK && mode_r == MODE_INSERT) ?
                      chosen_r[ADDR_BITS-1:0] : '0;
    end
  end

  // on insert entries shift up to open the slot; on remove they shift down
  for (genvar j = 0; j < MAX_NODES; j++) begin : g_ent
    always_ff @(posedge clk) begin
      if (cmd.ins_shift) begin
        if (idx_r == CNT_W'(j)) begin
          starts_r[j] <= chosen_r[ADDR_BITS-1:0];
          lens_r[j]   <= size_r;
        end else if (idx_r < CNT_W'(j)) begin
          if (j > 0) begin
            starts_r[j] <= starts_r[(j > 0) ? j - 1 : 0];
            lens_r[j]   <= lens_r[(j > 0) ? j - 1 : 0];
          end
        end
      end else if (cmd.rem_shift) begin
        if (idx_r <= CNT_W'(j) && j < MAX_NODES - 1) begin
          starts_r[j] <= starts_r[(j < MAX_NODES - 1) ? j + 1 : j];
          lens_r[j]   <= lens_r[(j < MAX_NODES - 1) ? j + 1 : j];
        end
      end
    end
  end

  assign out_status       = out_status_r;
  assign out_placed_start = out_placed_r;
endmodule
`default_nettype wire

@@ rtl/core/range_gap_allocator.sv @@
// top level of the range gap allocator
// channel | direction | word
// in_     | input     | mode, size, alignment, window, policy, once, node start
// out_    | output    | status, placed start
// cfg_    | input     | span start (0), span size (1), write only
// an insert checks the request, walks the gaps, scans for its position and, if a gap
// fits, shifts the table up; a remove scans for the key and, if found, shifts it down
// one word is in flight at a time; the gap walk reads one table entry in S_GAPA and
// evaluates its gap in S_GAPB, and the table shifts all entries in parallel
// synchronous active-low reset clears the entry count and the span registers
// a stalled result sits in the output register while the next word is taken; the
// next result then waits until the output register drains
`default_nettype none
module range_gap_allocator import rga_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire                  cfg_index,
  input  wire [SIZE_W-1:0]     cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_mode,
  input  wire [SIZE_W-1:0]     in_alloc_size,
  input  wire [ADDR_BITS-1:0]  in_alignment,
  input  wire [ADDR_BITS-1:0]  in_range_start,
  input  wire [SIZE_W-1:0]     in_range_end,
  input  wire [1:0]            in_fit_policy,
  input  wire                  in_once_flag,
  input  wire [ADDR_BITS-1:0]  in_node_start,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [2:0]           out_status,
  output logic [ADDR_BITS-1:0] out_placed_start
);
  cmd_t  cmd;
  stat_t st;

  rga_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
  );

  rga_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_mode(in_mode), .in_alloc_size(in_alloc_size),
    .in_alignment(in_alignment), .in_range_start(in_range_start),
    .in_range_end(in_range_end), .in_fit_policy(in_fit_policy),
    .in_once_flag(in_once_flag), .in_node_start(in_node_start),
    .out_valid(out_valid), .out_status(out_status),
    .out_placed_start(out_placed_start), .cmd(cmd), .st(st)
  );
endmodule
`default_nettype wire

@@ rtl/core/rga_checker.sv @@
// port-level checks for the range gap allocator, bound to the top level
`default_nettype none
`include "range_gap_allocator_macros.svh"
module rga_checker import rga_pkg::*; (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire [2:0]           out_status,
  input wire [ADDR_BITS-1:0] out_placed_start
);
  `RGA_ASSERT(a_status_code, out_valid |-> (out_status <= 3'(ST_FULL)), "bad status code")
  `RGA_ASSERT(a_fail_zero, (out_valid && out_status != 3'(ST_OK)) |-> (out_placed_start == '0), "placed start set on failure")
  `RGA_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "second word taken while busy")
  `RGA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status), "result dropped under stall")
endmodule

bind range_gap_allocator rga_checker u_rga_checker (.*);
`default_nettype wire
